// ===== rtl/core/sqe_pkg.sv =====
// ----------------------------------------------------------------------------
// sqe_pkg
// Shared constants and types for the square-mask erosion block.
// ----------------------------------------------------------------------------
package sqe_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 2;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HALF_DEF   = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_HALF    = 2'd2;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd700;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd700;
    localparam logic [1:0]       RST_MASK_HALF    = 2'd1;

    // input item kinds
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] pix;
    } t_out_beat;

endpackage

// ===== rtl/core/sqe_ram.sv =====
// ----------------------------------------------------------------------------
// sqe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/square_mask_erosion.sv =====
// ----------------------------------------------------------------------------
// square_mask_erosion
// Erosion of a raster-order 8-bit frame with a (2h+1)x(2h+1) square mask.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle on both sides while the output is not stalled,
//   set by the read-modify-write of the column stack RAM (one read and one
//   write port, one entry per column). Latency: a result passes the stage 1
//   registers and the output queue; the output lags the input by h*W+h beats.
// Reset: synchronous, active low; clears position counters, pipeline and output
//   queue and loads the register defaults. The line RAM is not cleared.
// ----------------------------------------------------------------------------
module square_mask_erosion #(
    parameter int MAX_WIDTH = sqe_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HALF  = sqe_pkg::MAX_HALF_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [sqe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sqe_pkg::CFG_W-1:0]     i_cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [sqe_pkg::PIX_W-1:0]     s_axis_tdata,  // [7:0] pixel
    input  logic                          s_axis_tuser,  // [0] cmd
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [sqe_pkg::PIX_W-1:0]     m_axis_tdata,  // [7:0] out_pixel
    output logic                          m_axis_tlast
);

    localparam int PW     = sqe_pkg::PIX_W;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = sqe_pkg::CFG_W;
    localparam int HALF_W = $clog2(MAX_HALF + 1);
    localparam int STK_N  = 2 * MAX_HALF;
    localparam int LAG_W  = $clog2(MAX_HALF * MAX_WIDTH + MAX_HALF + 1);

    // ---------------------------------------------------------------- config
    logic [sqe_pkg::CFG_W-1:0] r_cfg_width;
    logic [sqe_pkg::CFG_W-1:0] r_cfg_height;
    logic [1:0]                r_cfg_half;
    logic                      cfg_hit;

    assign cfg_hit = i_cfg_wr_en && (i_cfg_index == sqe_pkg::CFG_IMAGE_WIDTH ||
                                     i_cfg_index == sqe_pkg::CFG_IMAGE_HEIGHT ||
                                     i_cfg_index == sqe_pkg::CFG_MASK_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= sqe_pkg::RST_IMAGE_WIDTH;
            r_cfg_height <= sqe_pkg::RST_IMAGE_HEIGHT;
            r_cfg_half   <= sqe_pkg::RST_MASK_HALF;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sqe_pkg::CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                sqe_pkg::CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                sqe_pkg::CFG_MASK_HALF:    r_cfg_half   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // effective geometry
    logic [WID_W-1:0]  eff_w;
    logic [ROW_W-1:0]  eff_h;
    logic [HALF_W-1:0] eff_k;
    logic [LAG_W-1:0]  lag;

    always_comb begin
        if (r_cfg_width == '0) begin
            eff_w = WID_W'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(r_cfg_width);
        end
        eff_h = (r_cfg_height == '0) ? ROW_W'(1) : r_cfg_height;
        eff_k = (32'(r_cfg_half) > MAX_HALF) ? HALF_W'(MAX_HALF) : HALF_W'(r_cfg_half);
        lag   = LAG_W'(eff_k) * LAG_W'(eff_w) + LAG_W'(eff_k);
    end

    // ------------------------------------------------------- input position
    logic             r_busy;
    logic [COL_W-1:0] r_in_col;
    logic [ROW_W-1:0] r_in_row;
    logic [LAG_W-1:0] r_pre;
    logic             r_out_on;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;

    logic s_acc, s_take, in_frame, emit, at_edge, at_last;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    // a drain beat outside a frame is swallowed
    assign s_take   = s_acc && (r_busy || s_axis_tuser == sqe_pkg::CMD_PIXEL);
    assign in_frame = r_in_row < eff_h;
    assign emit     = r_out_on || (r_pre == lag);

    always_comb begin
        at_edge = (r_out_row < ROW_W'(eff_k)) || (r_out_col < COL_W'(eff_k)) ||
                  ((ROW_W + 1)'(r_out_row) + (ROW_W + 1)'(eff_k) >= (ROW_W + 1)'(eff_h)) ||
                  ((WID_W + 1)'(r_out_col) + (WID_W + 1)'(eff_k) >= (WID_W + 1)'(eff_w));
        at_last = ((ROW_W + 1)'(r_out_row) + 1'b1 == (ROW_W + 1)'(eff_h)) &&
                  ((WID_W + 1)'(r_out_col) + 1'b1 == (WID_W + 1)'(eff_w));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_busy    <= 1'b0;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_pre     <= '0;
            r_out_on  <= 1'b0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (s_take) begin
            if (emit && at_last) begin
                r_busy    <= 1'b0;
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_pre     <= '0;
                r_out_on  <= 1'b0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                r_busy <= 1'b1;
                if (in_frame) begin
                    if ((WID_W + 1)'(r_in_col) + 1'b1 == (WID_W + 1)'(eff_w)) begin
                        r_in_col <= '0;
                        r_in_row <= r_in_row + 1'b1;
                    end else begin
                        r_in_col <= r_in_col + 1'b1;
                    end
                end
                if (!r_out_on) begin
                    if (r_pre == lag) begin
                        r_out_on <= 1'b1;
                    end else begin
                        r_pre <= r_pre + 1'b1;
                    end
                end
                if (emit) begin
                    if ((WID_W + 1)'(r_out_col) + 1'b1 == (WID_W + 1)'(eff_w)) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + 1'b1;
                    end else begin
                        r_out_col <= r_out_col + 1'b1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------ column stack RAM
    // entry c holds the pixels of column c for the last 2*MAX_HALF rows,
    // slot 0 being the row just above the current input row
    logic [STK_N-1:0][PW-1:0] ram_rdata;
    logic [STK_N-1:0][PW-1:0] n_stack;
    logic [STK_N-1:0][PW-1:0] r_wb_data;
    logic [STK_N-1:0][PW-1:0] stack_rd;

    logic             r_s1_v;
    logic             r_s1_wr;
    logic             r_s1_out;
    logic             r_s1_edge;
    logic             r_s1_last;
    logic             r_s1_fwd;
    logic [COL_W-1:0] r_s1_col;
    logic [PW-1:0]    r_s1_pix;

    sqe_ram #(
        .WIDTH (STK_N * PW),
        .DEPTH (MAX_WIDTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_v && r_s1_wr),
        .i_waddr (r_s1_col),
        .i_wdata (n_stack),
        .i_raddr (r_in_col),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= s_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_s1_wr   <= in_frame;
            r_s1_out  <= emit;
            r_s1_edge <= at_edge;
            r_s1_last <= at_last;
            r_s1_col  <= r_in_col;
            r_s1_pix  <= (s_axis_tuser == sqe_pkg::CMD_DRAIN) ? '0 : s_axis_tdata;
            // same column written back this edge: RAM read returns old data
            r_s1_fwd  <= r_s1_v && r_s1_wr && (r_s1_col == r_in_col);
        end
        if (r_s1_v && r_s1_wr) begin
            r_wb_data <= n_stack;
        end
    end

    assign stack_rd = r_s1_fwd ? r_wb_data : ram_rdata;

    always_comb begin
        n_stack[0] = r_s1_pix;
        for (int j = 1; j < STK_N; j++) begin
            n_stack[j] = stack_rd[j-1];
        end
    end

    // --------------------------------------------------------------- window
    // per column: all 2h+1 pixels nonzero, and the value of the centre row
    logic                r_col_nz  [1:STK_N];
    logic [PW-1:0]       r_col_ctr [1:MAX_HALF];
    logic                col_nz;
    logic [PW-1:0]       col_ctr;
    logic                win_ok;
    logic [PW-1:0]       win_ctr;
    sqe_pkg::t_out_beat  s1_beat;

    always_comb begin
        col_nz  = (r_s1_pix != '0);
        col_ctr = r_s1_pix;
        for (int j = 0; j < STK_N; j++) begin
            if (j < 2 * int'(eff_k) && stack_rd[j] == '0) begin
                col_nz = 1'b0;
            end
            if (j + 1 == int'(eff_k)) begin
                col_ctr = stack_rd[j];
            end
        end
        win_ok  = col_nz;
        win_ctr = col_ctr;
        for (int k = 1; k <= STK_N; k++) begin
            if (k <= 2 * int'(eff_k) && !r_col_nz[k]) begin
                win_ok = 1'b0;
            end
        end
        for (int k = 1; k <= MAX_HALF; k++) begin
            if (k == int'(eff_k)) begin
                win_ctr = r_col_ctr[k];
            end
        end
        s1_beat.last = r_s1_last;
        s1_beat.pix  = (r_s1_edge || !win_ok) ? '0 : win_ctr;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_col_nz[1]  <= col_nz;
            r_col_ctr[1] <= col_ctr;
            for (int k = 2; k <= STK_N; k++) begin
                r_col_nz[k] <= r_col_nz[k-1];
            end
            for (int k = 2; k <= MAX_HALF; k++) begin
                r_col_ctr[k] <= r_col_ctr[k-1];
            end
        end
    end

    // --------------------------------------------------------- output queue
    // three entries; ready also counts the beat in stage 1, so ready depends
    // on registers only and a beat still enters every cycle unless the output stalls
    localparam logic [1:0] Q_TOP = 2'd2;

    sqe_pkg::t_out_beat r_q [3];
    logic [1:0]         r_wp;
    logic [1:0]         r_rp;
    logic [1:0]         r_occ;
    logic               q_push;
    logic               q_pop;

    assign q_push = r_s1_v && r_s1_out;
    assign q_pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_occ <= '0;
        end else begin
            if (q_push) begin
                r_wp <= (r_wp == Q_TOP) ? 2'd0 : r_wp + 1'b1;
            end
            if (q_pop) begin
                r_rp <= (r_rp == Q_TOP) ? 2'd0 : r_rp + 1'b1;
            end
            case ({q_push, q_pop})
                2'b10:   r_occ <= r_occ + 1'b1;
                2'b01:   r_occ <= r_occ - 1'b1;
                default: r_occ <= r_occ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_wp] <= s1_beat;
        end
    end

    assign s_axis_tready = ({1'b0, r_occ} + {2'b00, r_s1_v}) < 3'd3;
    assign m_axis_tvalid = (r_occ != '0);
    assign m_axis_tdata  = r_q[r_rp].pix;
    assign m_axis_tlast  = r_q[r_rp].last;

endmodule
